FILE: hdl/msit_pkg.sv
`default_nettype none

package msit_pkg;

    // Default sizes of the slot table.
    localparam int NUM_SLOTS_DEF     = 16;
    localparam int INTERVAL_BITS_DEF = 16;

    // Operation carried by each input item.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_FIRE     = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    // One input item.
    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] interval;
        logic        repeats;
        logic [3:0]  slot;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_status    status;
        logic [3:0] slot_number;
        logic       fired;
        logic       last;
    } t_out_item;

    // What the head unit saw on the slot passing through it.
    typedef struct packed {
        logic fire;   // slot expired on this tick
        logic claim;  // free slot taken by a register operation
        logic hit;    // target slot of remove or fire-now is in use
    } t_head_flags;

endpackage

`default_nettype wire

FILE: hdl/msit_cell.sv
`default_nettype none

module msit_cell
    import msit_pkg::*;
#(
    parameter int DATA_W = 33
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire logic              i_valid,
    input  wire logic [DATA_W-1:0] i_rec,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_rec
);

    logic              r_valid;
    logic [DATA_W-1:0] r_rec;

    // The in-use flag is cleared at reset; the slot fields only matter while it is set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // Slot fields move one place toward the head on every step of a walk.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

`default_nettype wire

FILE: hdl/msit_head.sv
`default_nettype none

module msit_head
    import msit_pkg::*;
#(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  wire t_opcode                  i_op,
    input  wire logic [INTERVAL_BITS-1:0] i_iv,
    input  wire logic                     i_rep,
    input  wire logic                     i_target,
    input  wire logic                     i_found,
    input  wire logic                     i_valid,
    input  wire logic [2*INTERVAL_BITS:0] i_rec,
    output logic                          o_valid,
    output logic [2*INTERVAL_BITS:0]      o_rec,
    output t_head_flags                   o_flags
);

    localparam int IB    = INTERVAL_BITS;
    localparam int REC_W = 2 * IB + 1;

    logic          w_rep;
    logic [IB-1:0] w_ivl;
    logic [IB-1:0] w_tl;

    // Record layout: repeat flag, interval, time left.
    assign w_rep = i_rec[REC_W-1];
    assign w_ivl = i_rec[2*IB-1:IB];
    assign w_tl  = i_rec[IB-1:0];

    // Update of the slot that sits at the head of the ring.
    always_comb begin
        o_valid = i_valid;
        o_rec   = i_rec;
        o_flags = '0;
        case (i_op)
            OP_TICK: begin
                if (i_valid) begin
                    if (w_tl <= IB'(1)) begin
                        o_flags.fire = 1'b1;
                        if (w_rep) begin
                            o_rec = {w_rep, w_ivl, w_ivl};
                        end else begin
                            o_valid = 1'b0;
                            o_rec   = '0;
                        end
                    end else begin
                        o_rec = {w_rep, w_ivl, w_tl - IB'(1)};
                    end
                end
            end
            OP_REGISTER: begin
                if (!i_found && !i_valid) begin
                    o_flags.claim = 1'b1;
                    o_valid       = 1'b1;
                    o_rec         = {i_rep, i_iv, i_iv};
                end
            end
            OP_REMOVE: begin
                if (i_target && i_valid) begin
                    o_flags.hit = 1'b1;
                    o_valid     = 1'b0;
                    o_rec       = '0;
                end
            end
            OP_FIRE: begin
                if (i_target && i_valid) begin
                    o_flags.hit = 1'b1;
                    o_rec       = {w_rep, w_ivl, IB'(0)};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/multi_slot_interval_timer.sv
// Channel | Direction | Payload     | Handshake
// in      | input     | t_in_item   | i_in_valid, o_in_stall
// out     | output    | t_out_item  | o_out_valid, i_out_stall
//
// Every item walks the whole slot ring once: it is accepted, the ring takes
// NUM_SLOTS steps, and then the final result is loaded.
// One slot passes the head unit per step.
// A stalled output freezes the walk until the output register is taken.
// Reset clears every slot; the block takes items in the cycle after reset.
// o_in_stall is high from accept until the final result is loaded.
`default_nettype none

module multi_slot_interval_timer
    import msit_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_item,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_item     o_out_item,
    input  wire logic     i_out_stall
);

    localparam int IB    = INTERVAL_BITS;
    localparam int REC_W = 2 * IB + 1;
    localparam int CNT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state;
    t_opcode         r_op;
    logic [IB-1:0]   r_iv;
    logic            r_rep;
    logic [3:0]      r_slot;
    logic [CNT_W-1:0] r_cnt;
    logic            r_found;
    logic [3:0]      r_claim_slot;
    logic            r_hit;
    logic            r_pend_valid;
    logic [3:0]      r_pend_slot;
    logic            r_out_valid;
    t_out_item       r_out_item;

    logic             w_valid [NUM_SLOTS];
    logic [REC_W-1:0] w_rec   [NUM_SLOTS];
    logic             w_head_valid;
    logic [REC_W-1:0] w_head_rec;
    t_head_flags      w_flags;
    logic             w_can_load;
    logic             w_step;
    logic             w_load;
    logic             w_target;
    logic [IDX_W-1:0] w_cnt_ext;
    logic [3:0]       w_cnt_slot;
    logic [IB-1:0]    w_in_iv;

    // The output register can take a new result when empty or being drained.
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign w_step     = (r_state == S_WALK) && w_can_load;

    // A result is loaded for a firing that has a successor, and at the end of the walk.
    assign w_load = (w_step && w_flags.fire && r_pend_valid) ||
                    ((r_state == S_DONE) && w_can_load);

    assign w_cnt_ext  = IDX_W'(r_cnt);
    assign w_cnt_slot = w_cnt_ext[3:0];
    assign w_target   = (IDX_W'(r_slot) == w_cnt_ext);

    // An interval of zero is stored as one.
    assign w_in_iv = (IB'(i_in_item.interval) == '0) ? IB'(1) : IB'(i_in_item.interval);

    // Ring of slot cells; slot r_cnt sits in cell 0 during a walk.
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
        if (k == NUM_SLOTS - 1) begin : g_tail
            msit_cell #(.DATA_W(REC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_valid (w_head_valid),
                .i_rec   (w_head_rec),
                .o_valid (w_valid[k]),
                .o_rec   (w_rec[k])
            );
        end else begin : g_body
            msit_cell #(.DATA_W(REC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_valid (w_valid[k+1]),
                .i_rec   (w_rec[k+1]),
                .o_valid (w_valid[k]),
                .o_rec   (w_rec[k])
            );
        end
    end

    // Head unit applies the current operation to the slot leaving cell 0.
    msit_head #(.INTERVAL_BITS(IB)) u_head (
        .i_op     (r_op),
        .i_iv     (r_iv),
        .i_rep    (r_rep),
        .i_target (w_target),
        .i_found  (r_found),
        .i_valid  (w_valid[0]),
        .i_rec    (w_rec[0]),
        .o_valid  (w_head_valid),
        .o_rec    (w_head_rec),
        .o_flags  (w_flags)
    );

    // Sequencer: accept, walk the ring, deliver the final result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_found      <= 1'b0;
            r_hit        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            // The output register fills on a load and empties once taken.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op         <= i_in_item.opcode;
                        r_iv         <= w_in_iv;
                        r_rep        <= i_in_item.repeats;
                        r_slot       <= i_in_item.slot;
                        r_cnt        <= '0;
                        r_found      <= 1'b0;
                        r_hit        <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_can_load) begin
                        r_cnt <= CNT_W'(r_cnt + 1'b1);
                        if (w_flags.claim) begin
                            r_found      <= 1'b1;
                            r_claim_slot <= w_cnt_slot;
                        end
                        if (w_flags.hit) begin
                            r_hit <= 1'b1;
                        end
                        // A firing is held back until we know whether it is the last one.
                        if (w_flags.fire) begin
                            if (r_pend_valid) begin
                                r_out_item  <= '{status: ST_OK, slot_number: r_pend_slot,
                                                 fired: 1'b1, last: 1'b0};
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_slot  <= w_cnt_slot;
                        end
                        if (r_cnt == CNT_W'(NUM_SLOTS - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_can_load) begin
                        r_state     <= S_IDLE;
                        case (r_op)
                            OP_TICK: begin
                                if (r_pend_valid) begin
                                    r_out_item <= '{status: ST_OK, slot_number: r_pend_slot,
                                                    fired: 1'b1, last: 1'b1};
                                end else begin
                                    r_out_item <= '{status: ST_OK, slot_number: 4'd0,
                                                    fired: 1'b0, last: 1'b1};
                                end
                            end
                            OP_REGISTER: begin
                                if (r_found) begin
                                    r_out_item <= '{status: ST_OK, slot_number: r_claim_slot,
                                                    fired: 1'b0, last: 1'b1};
                                end else begin
                                    r_out_item <= '{status: ST_FULL, slot_number: 4'd0,
                                                    fired: 1'b0, last: 1'b1};
                                end
                            end
                            default: begin
                                r_out_item <= '{status: r_hit ? ST_OK : ST_NOT_USED,
                                                slot_number: r_slot, fired: 1'b0, last: 1'b1};
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: hdl/msit_checker.sv
`default_nettype none

module msit_checker
    import msit_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_item,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_item,
    input wire logic      i_out_stall
);

    // Only one item is worked on at a time: an accept is followed by a stall.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // A result that is waiting keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // Only a firing slot can be followed by more results of the same item.
    a_last_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.fired) |-> o_out_item.last)
        else $error("non-firing result not marked last");

    // A firing is always reported with status ok.
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.fired) |-> (o_out_item.status == ST_OK))
        else $error("firing result with error status");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multi_slot_interval_timer msit_checker u_msit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
